[sv/scm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_pkg
// Shared types, codes and widths for the servo pulse calibration map.
// ============================================================================
package scm_pkg;

    // Quotient bits produced by the divider pipeline, one bit per stage.
    localparam int QW = 18;
    // Divisor and partial remainder width.
    localparam int DW = 18;

    typedef logic [1:0] t_action;
    localparam t_action ACT_ANGLE_TO_PULSE = 2'd0;
    localparam t_action ACT_OPEN_TO_PULSE  = 2'd1;
    localparam t_action ACT_PULSE_TO_ANGLE = 2'd2;
    localparam t_action ACT_PULSE_TO_OPEN  = 2'd3;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_MIN_US     = 3'd0;
    localparam t_reg_idx REG_CENTER_US  = 3'd1;
    localparam t_reg_idx REG_MAX_US     = 3'd2;
    localparam t_reg_idx REG_INVERT_DIR = 3'd3;
    localparam t_reg_idx REG_CLOSED_US  = 3'd4;
    localparam t_reg_idx REG_HALF_US    = 3'd5;
    localparam t_reg_idx REG_OPEN_US    = 3'd6;

    // Calibration register set.
    typedef struct packed {
        logic [15:0] min_us;
        logic [15:0] center_us;
        logic [15:0] max_us;
        logic        invert_dir;
        logic [15:0] closed_us;
        logic [15:0] half_us;
        logic [15:0] open_us;
    } t_cfg;

    // Operands of the shared multiply-add: value = x * y + b, then floor by d.
    typedef struct packed {
        t_action            action;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [35:0] b;
        logic [DW-1:0]      d;
        logic [16:0]        off;
    } t_mul;

    // Divider pipeline word: partial remainder, dividend bits still to be
    // consumed at the top of lq and quotient bits gathered at its bottom.
    typedef struct packed {
        t_action       action;
        logic [DW-1:0] rem;
        logic [QW-1:0] lq;
        logic [DW-1:0] d;
        logic          neg;
        logic [16:0]   off;
    } t_div;

endpackage

[sv/scm_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_in_if
// Request channel: one conversion request per word.
// ============================================================================
interface scm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] angle_in;
    logic [16:0]        openness_in;
    logic [15:0]        pulse_in;

    modport source (output valid, action, angle_in, openness_in, pulse_in, input ready);
    modport sink   (input valid, action, angle_in, openness_in, pulse_in, output ready);
endinterface

[sv/scm_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_out_if
// Result channel: one conversion result per word.
// ============================================================================
interface scm_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pulse_out;
    logic signed [14:0] angle_out;
    logic [16:0]        openness_out;

    modport source (output valid, pulse_out, angle_out, openness_out, input ready);
    modport sink   (input valid, pulse_out, angle_out, openness_out, output ready);
endinterface

[sv/servo_pulse_calibration_map_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// servo_pulse_calibration_map_unit
// Per-servo calibration: gaze angle and lid openness to pulse width and back.
// ============================================================================
// The unit accepts one request word per clock cycle unless the result side
// stalls, and returns one result word for each, in order, through two decode
// stages, a multiply, an add, a sign fold, an 18-stage restoring divider that
// produces one quotient bit per stage, and the output register. The divider
// pipeline sets the latency; throughput is one word per cycle unless stalled.
// Both handshakes may stall at any time; stages with bubbles keep filling
// while the result side waits. The user must write calibration registers over
// APB only while no request is in flight; the unit does not enforce it.
module servo_pulse_calibration_map_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scm_in_if.sink      i_in,
    scm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    scm_pkg::t_cfg        r_cfg;
    scm_pkg::t_reg_idx    reg_idx;
    logic                 f_valid, f_ready;
    scm_pkg::t_mul        f_data;
    logic [scm_pkg::QW:0] w_v, w_r;
    scm_pkg::t_div        w_d [scm_pkg::QW+1];

    logic                 r_ov;
    logic [15:0]          r_pulse, n_pulse;
    logic signed [14:0]   r_angle, n_angle;
    logic [16:0]          r_open, n_open;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_us     <= 16'd1000;
            r_cfg.center_us  <= 16'd1500;
            r_cfg.max_us     <= 16'd2000;
            r_cfg.invert_dir <= 1'b0;
            r_cfg.closed_us  <= 16'd1000;
            r_cfg.half_us    <= 16'd1500;
            r_cfg.open_us    <= 16'd2000;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                scm_pkg::REG_MIN_US:     r_cfg.min_us     <= pwdata[15:0];
                scm_pkg::REG_CENTER_US:  r_cfg.center_us  <= pwdata[15:0];
                scm_pkg::REG_MAX_US:     r_cfg.max_us     <= pwdata[15:0];
                scm_pkg::REG_INVERT_DIR: r_cfg.invert_dir <= pwdata[0];
                scm_pkg::REG_CLOSED_US:  r_cfg.closed_us  <= pwdata[15:0];
                scm_pkg::REG_HALF_US:    r_cfg.half_us    <= pwdata[15:0];
                scm_pkg::REG_OPEN_US:    r_cfg.open_us    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            scm_pkg::REG_MIN_US:     prdata = {16'd0, r_cfg.min_us};
            scm_pkg::REG_CENTER_US:  prdata = {16'd0, r_cfg.center_us};
            scm_pkg::REG_MAX_US:     prdata = {16'd0, r_cfg.max_us};
            scm_pkg::REG_INVERT_DIR: prdata = {31'd0, r_cfg.invert_dir};
            scm_pkg::REG_CLOSED_US:  prdata = {16'd0, r_cfg.closed_us};
            scm_pkg::REG_HALF_US:    prdata = {16'd0, r_cfg.half_us};
            scm_pkg::REG_OPEN_US:    prdata = {16'd0, r_cfg.open_us};
            default:                 prdata = 32'd0;
        endcase
    end

    scm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_action (i_in.action),
        .i_angle  (i_in.angle_in),
        .i_open   (i_in.openness_in),
        .i_pulse  (i_in.pulse_in),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_data   (f_data)
    );

    scm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (w_v[0]),
        .i_ready (w_r[0]),
        .o_data  (w_d[0])
    );

    // Quotient pipeline, one bit per stage.
    for (genvar g = 0; g < scm_pkg::QW; g++) begin : g_div
        scm_divstage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    assign w_r[scm_pkg::QW] = !r_ov || o_out.ready;

    // Sign, offset and saturation of the quotient for each action.
    always_comb begin
        logic signed [18:0] q19, qs;
        q19     = {1'b0, w_d[scm_pkg::QW].lq};
        qs      = w_d[scm_pkg::QW].neg ? -q19 : q19;
        n_pulse = 16'd0;
        n_angle = '0;
        n_open  = 17'd0;
        unique case (w_d[scm_pkg::QW].action)
            scm_pkg::ACT_ANGLE_TO_PULSE, scm_pkg::ACT_OPEN_TO_PULSE: begin
                if (qs < 19'sd0) begin
                    n_pulse = 16'd0;
                end else if (qs > 19'sd65535) begin
                    n_pulse = 16'hFFFF;
                end else begin
                    n_pulse = qs[15:0];
                end
            end
            scm_pkg::ACT_PULSE_TO_ANGLE: begin
                n_angle = qs[14:0];
            end
            scm_pkg::ACT_PULSE_TO_OPEN: begin
                n_open = qs[16:0] + w_d[scm_pkg::QW].off;
            end
            default: begin
                n_open = 17'd0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_r[scm_pkg::QW]) begin
            r_ov <= w_v[scm_pkg::QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r[scm_pkg::QW] && w_v[scm_pkg::QW]) begin
            r_pulse <= n_pulse;
            r_angle <= n_angle;
            r_open  <= n_open;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.pulse_out    = r_pulse;
    assign o_out.angle_out    = r_angle;
    assign o_out.openness_out = r_open;

    // The divider leaves a remainder below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[scm_pkg::QW] |-> (w_d[scm_pkg::QW].rem < w_d[scm_pkg::QW].d))
        else $error("divider remainder not below divisor");

    // Inverse lid mapping never goes beyond fully open.
    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_open <= 17'd65536))
        else $error("openness result beyond full open");

    // Inverse gaze mapping stays within plus or minus 45 degrees.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_angle >= -15'sd11520) && (r_angle <= 15'sd11520)))
        else $error("angle result beyond 45 degrees");

endmodule

[sv/scm_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_front
// Two decode stages: clamping, mirroring and span selection, producing the
// operands of the multiply-add and the divisor for each action.
// ============================================================================
module scm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scm_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  scm_pkg::t_action    i_action,
    input  logic signed [15:0]  i_angle,
    input  logic [16:0]         i_open,
    input  logic [15:0]         i_pulse,
    output logic                o_valid,
    input  logic                i_ready,
    output scm_pkg::t_mul       o_data
);

    localparam logic signed [15:0] GAZE_LIM = 16'sd11520;

    typedef struct packed {
        scm_pkg::t_action   action;
        logic signed [14:0] a;
        logic signed [16:0] d_pos;
        logic signed [16:0] d_neg;
        logic               p_ge_c;
        logic signed [16:0] t;
        logic               n_hi;
        logic [16:0]        n_k;
        logic signed [16:0] sl_lo;
        logic signed [16:0] sl_hi;
        logic signed [16:0] pm;
        logic signed [16:0] clm;
        logic signed [16:0] hfm;
        logic signed [16:0] opm;
    } t_dec;

    logic          r_v1, r_v2;
    t_dec          r_s1, n_s1;
    scm_pkg::t_mul r_s2, n_s2;
    logic          ok1, ok2;

    assign ok2     = !r_v2 || i_ready;
    assign ok1     = !r_v1 || ok2;
    assign o_ready = ok1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    // Stage one: clamp the inputs, form the spans and mirror the lid points.
    always_comb begin
        logic signed [15:0] ang;
        logic signed [14:0] ac;
        logic [16:0]        nc;
        logic               mir;
        logic signed [16:0] pe, cle, hfe, ope;
        ang = i_angle;
        if (i_angle > GAZE_LIM) begin
            ang = GAZE_LIM;
        end else if (i_angle < -GAZE_LIM) begin
            ang = -GAZE_LIM;
        end
        ac = ang[14:0];
        n_s1.action = i_action;
        n_s1.a      = i_cfg.invert_dir ? -ac : ac;
        n_s1.d_pos  = {1'b0, i_cfg.max_us} - {1'b0, i_cfg.center_us};
        n_s1.d_neg  = {1'b0, i_cfg.center_us} - {1'b0, i_cfg.min_us};
        n_s1.p_ge_c = i_pulse >= i_cfg.center_us;
        n_s1.t      = {1'b0, i_pulse} - {1'b0, i_cfg.center_us};
        nc          = (i_open > 17'd65536) ? 17'd65536 : i_open;
        n_s1.n_hi   = nc > 17'd32768;
        n_s1.n_k    = n_s1.n_hi ? nc - 17'd32768 : nc;
        n_s1.sl_lo  = {1'b0, i_cfg.half_us} - {1'b0, i_cfg.closed_us};
        n_s1.sl_hi  = {1'b0, i_cfg.open_us} - {1'b0, i_cfg.half_us};
        // A lid that opens toward shorter pulses is handled by negating all points.
        mir         = i_cfg.open_us < i_cfg.closed_us;
        pe          = {1'b0, i_pulse};
        cle         = {1'b0, i_cfg.closed_us};
        hfe         = {1'b0, i_cfg.half_us};
        ope         = {1'b0, i_cfg.open_us};
        n_s1.pm     = mir ? -pe : pe;
        n_s1.clm    = mir ? -cle : cle;
        n_s1.hfm    = mir ? -hfe : hfe;
        n_s1.opm    = mir ? -ope : ope;
    end

    // Stage two: pick the multiply-add operands, divisor and offset per action.
    always_comb begin
        logic signed [16:0] d0, d2, tc;
        logic signed [17:0] dm, xm;
        logic [15:0]        c, base;
        d0   = '0;
        d2   = '0;
        tc   = '0;
        dm   = '0;
        xm   = '0;
        c    = i_cfg.center_us;
        base = r_s1.n_hi ? i_cfg.half_us : i_cfg.closed_us;
        n_s2        = '0;
        n_s2.action = r_s1.action;
        n_s2.d      = 18'd1;
        unique case (r_s1.action)
            scm_pkg::ACT_ANGLE_TO_PULSE: begin
                d0     = r_s1.a[14] ? r_s1.d_neg : r_s1.d_pos;
                n_s2.x = 18'(r_s1.a);
                n_s2.y = 18'(d0);
                // center * 11520 as a sum of shifts, plus one half for rounding.
                n_s2.b = 36'({c, 13'b0}) + 36'({c, 11'b0}) + 36'({c, 10'b0})
                       + 36'({c, 8'b0}) + 36'sd5760;
                n_s2.d = 18'd11520;
            end
            scm_pkg::ACT_OPEN_TO_PULSE: begin
                n_s2.x = {1'b0, r_s1.n_k};
                n_s2.y = 18'(r_s1.n_hi ? r_s1.sl_hi : r_s1.sl_lo);
                n_s2.b = 36'({base, 15'b0}) + 36'sd16384;
                n_s2.d = 18'd32768;
            end
            scm_pkg::ACT_PULSE_TO_ANGLE: begin
                d2 = r_s1.p_ge_c ? r_s1.d_pos : r_s1.d_neg;
                if (d2 > 17'sd0) begin
                    tc = r_s1.t;
                    if (r_s1.t > d2) begin
                        tc = d2;
                    end else if (r_s1.t < -d2) begin
                        tc = -d2;
                    end
                    if (i_cfg.invert_dir) begin
                        tc = -tc;
                    end
                    n_s2.x = 18'(tc);
                    n_s2.y = 18'sd23040;
                    n_s2.b = 36'(d2);
                    n_s2.d = {d2, 1'b0};
                end
            end
            scm_pkg::ACT_PULSE_TO_OPEN: begin
                if (r_s1.pm <= r_s1.clm) begin
                    n_s2.off = 17'd0;
                end else if (r_s1.pm >= r_s1.opm) begin
                    n_s2.off = 17'd65536;
                end else begin
                    if (r_s1.pm <= r_s1.hfm) begin
                        dm = 18'(r_s1.hfm) - 18'(r_s1.clm);
                        xm = 18'(r_s1.pm) - 18'(r_s1.clm);
                    end else begin
                        dm       = 18'(r_s1.opm) - 18'(r_s1.hfm);
                        xm       = 18'(r_s1.pm) - 18'(r_s1.hfm);
                        n_s2.off = 17'd32768;
                    end
                    n_s2.x = xm;
                    n_s2.y = 18'sd65536;
                    n_s2.b = 36'(dm);
                    n_s2.d = {dm[16:0], 1'b0};
                end
            end
            default: begin
                n_s2.d = 18'd1;
            end
        endcase
    end

    // Stage registers with valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ok1) begin
                r_v1 <= i_valid;
            end
            if (ok2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ok1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (ok2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

endmodule

[sv/scm_prep.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_prep
// Multiply, add and sign fold: turns x*y+b into an unsigned dividend whose
// quotient by d gives the floor of the signed value.
// ============================================================================
module scm_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  scm_pkg::t_mul i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output scm_pkg::t_div o_data
);

    typedef struct packed {
        scm_pkg::t_action   action;
        logic signed [35:0] v;
        logic signed [35:0] b;
        logic [17:0]        d;
        logic [16:0]        off;
    } t_acc;

    logic          r_vm, r_va, r_vf;
    t_acc          r_m, r_a;
    scm_pkg::t_div r_f, n_f;
    logic          okm, oka, okf;
    logic [35:0]   mag;

    assign okf     = !r_vf || i_ready;
    assign oka     = !r_va || okf;
    assign okm     = !r_vm || oka;
    assign o_ready = okm;
    assign o_valid = r_vf;
    assign o_data  = r_f;

    // A negative value is floored by dividing (-v + d - 1) and negating after.
    always_comb begin
        if (r_a.v[35]) begin
            mag = 36'd0 - r_a.v + 36'(r_a.d) - 36'd1;
        end else begin
            mag = r_a.v;
        end
        n_f.action = r_a.action;
        n_f.rem    = {1'b0, mag[34:18]};
        n_f.lq     = mag[17:0];
        n_f.d      = r_a.d;
        n_f.neg    = r_a.v[35];
        n_f.off    = r_a.off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_va <= 1'b0;
            r_vf <= 1'b0;
        end else begin
            if (okm) begin
                r_vm <= i_valid;
            end
            if (oka) begin
                r_va <= r_vm;
            end
            if (okf) begin
                r_vf <= r_va;
            end
        end
    end

    // Product stage, sum stage, fold stage.
    always_ff @(posedge i_clk) begin
        if (okm && i_valid) begin
            r_m.action <= i_data.action;
            r_m.v      <= i_data.x * i_data.y;
            r_m.b      <= i_data.b;
            r_m.d      <= i_data.d;
            r_m.off    <= i_data.off;
        end
        if (oka && r_vm) begin
            r_a.action <= r_m.action;
            r_a.v      <= r_m.v + r_m.b;
            r_a.b      <= r_m.b;
            r_a.d      <= r_m.d;
            r_a.off    <= r_m.off;
        end
        if (okf && r_va) begin
            r_f <= n_f;
        end
    end

endmodule

[sv/scm_divstage.sv]
`timescale 1ns / 1ps
// ============================================================================
// scm_divstage
// One restoring division step: brings down one dividend bit and yields one
// quotient bit.
// ============================================================================
module scm_divstage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  scm_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output scm_pkg::t_div o_data
);

    logic                  r_valid;
    scm_pkg::t_div         r_data, n_data;
    logic [scm_pkg::DW:0]  trial, diff;
    logic                  ge;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Compare and subtract; the remainder stays below the divisor.
    always_comb begin
        trial       = {i_data.rem, i_data.lq[scm_pkg::QW-1]};
        diff        = trial - {1'b0, i_data.d};
        ge          = trial >= {1'b0, i_data.d};
        n_data      = i_data;
        n_data.rem  = ge ? diff[scm_pkg::DW-1:0] : trial[scm_pkg::DW-1:0];
        n_data.lq   = {i_data.lq[scm_pkg::QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[test/servo_pulse_calibration_map_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// servo_pulse_calibration_map_unit_tb
// Self-checking bench for the servo calibration map unit.
// ============================================================================
// Each accepted request word is converted by an integer model of the four
// conversions under the current calibration, and the expected result is
// queued. Result words are compared field by field, in order. Calibration
// is rewritten over APB between phases while the unit is idle, covering the
// reset values, extreme and degenerate spans, and inversion. Both handshakes
// see random gaps, and one long result stall fills the pipeline.
module servo_pulse_calibration_map_unit_tb;

    localparam int GAZE_FULL = 11520;
    localparam int HALF_OPEN = 32768;
    localparam int FULL_OPEN = 65536;
    localparam int LATENCY   = 24;

    typedef struct {
        logic [15:0] pulse;
        logic [14:0] angle;
        logic [16:0] openness;
    } t_result;

    // Calibration copy held by the bench.
    typedef struct {
        longint min_us, center_us, max_us, invert_dir, closed_us, half_us, open_us;
    } t_cal;

    // Floor division for a positive divisor.
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clip16(longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // Computes the result word that a request produces under a calibration.
    function automatic t_result convert(t_cal c, scm_pkg::t_action act,
                                        logic signed [15:0] ang,
                                        logic [16:0] opn, logic [15:0] pls);
        t_result r;
        longint a, n, p, d, num, cl, hf, op, v;
        r = '{pulse: '0, angle: '0, openness: '0};
        case (act)
            scm_pkg::ACT_ANGLE_TO_PULSE: begin
                a = ang;
                if (a > GAZE_FULL) a = GAZE_FULL;
                if (a < -GAZE_FULL) a = -GAZE_FULL;
                if (c.invert_dir != 0) a = -a;
                d = (a >= 0) ? c.max_us - c.center_us : c.center_us - c.min_us;
                r.pulse = 16'(clip16(floor_div(c.center_us * GAZE_FULL + a * d
                                               + GAZE_FULL / 2, GAZE_FULL)));
            end
            scm_pkg::ACT_OPEN_TO_PULSE: begin
                n = opn;
                if (n > FULL_OPEN) n = FULL_OPEN;
                if (n <= HALF_OPEN) num = c.closed_us * HALF_OPEN + n * (c.half_us - c.closed_us);
                else num = c.half_us * HALF_OPEN + (n - HALF_OPEN) * (c.open_us - c.half_us);
                r.pulse = 16'(clip16(floor_div(num + HALF_OPEN / 2, HALF_OPEN)));
            end
            scm_pkg::ACT_PULSE_TO_ANGLE: begin
                p = pls;
                d = (p >= c.center_us) ? c.max_us - c.center_us : c.center_us - c.min_us;
                v = 0;
                if (d > 0) begin
                    num = (p - c.center_us) * GAZE_FULL;
                    if (num > d * GAZE_FULL) num = d * GAZE_FULL;
                    if (num < -d * GAZE_FULL) num = -d * GAZE_FULL;
                    if (c.invert_dir != 0) num = -num;
                    v = floor_div(2 * num + d, 2 * d);
                end
                r.angle = v[14:0];
            end
            default: begin
                p = pls; cl = c.closed_us; hf = c.half_us; op = c.open_us;
                // Mirror the points when the lid pulse falls as it opens.
                if (op < cl) begin
                    p = -p; cl = -cl; hf = -hf; op = -op;
                end
                if (p <= cl) v = 0;
                else if (p >= op) v = FULL_OPEN;
                else if (p <= hf) begin
                    d = hf - cl;
                    v = floor_div(2 * HALF_OPEN * (p - cl) + d, 2 * d);
                end else begin
                    d = op - hf;
                    v = HALF_OPEN + floor_div(2 * HALF_OPEN * (p - hf) + d, 2 * d);
                end
                r.openness = v[16:0];
            end
        endcase
        return r;
    endfunction

    // Scoreboard: holds the calibration and the results still owed.
    class conversion_board;
        t_cal    cal;
        t_result owed[$];
        int      errors;
        int      checked;

        function void note_request(scm_pkg::t_action act, logic signed [15:0] ang,
                                   logic [16:0] opn, logic [15:0] pls);
            owed.push_back(convert(cal, act, ang, opn, pls));
        endfunction

        function void check_result(logic [15:0] pls, logic [14:0] ang, logic [16:0] opn);
            t_result e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word p=%0d a=%0d o=%0d",
                                           pls, ang, opn);
                return;
            end
            e = owed.pop_front();
            checked++;
            if (e.pulse !== pls || e.angle !== ang || e.openness !== opn) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected p=%0d a=%0d o=%0d, got p=%0d a=%0d o=%0d",
                             checked, e.pulse, $signed(e.angle), e.openness,
                             pls, $signed(ang), opn);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scm_in_if  req_ch ();
    scm_out_if res_ch ();

    servo_pulse_calibration_map_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    conversion_board board;
    bit  hold_off;
    int  sent;

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Writes one calibration register; the bench copy follows.
    task automatic write_reg(scm_pkg::t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = {16'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            scm_pkg::REG_MIN_US:     board.cal.min_us = val;
            scm_pkg::REG_CENTER_US:  board.cal.center_us = val;
            scm_pkg::REG_MAX_US:     board.cal.max_us = val;
            scm_pkg::REG_INVERT_DIR: board.cal.invert_dir = val[0];
            scm_pkg::REG_CLOSED_US:  board.cal.closed_us = val;
            scm_pkg::REG_HALF_US:    board.cal.half_us = val;
            default:                 board.cal.open_us = val;
        endcase
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic load_cal(int mn, int ct, int mx, int inv, int cl, int hf, int op);
        write_reg(scm_pkg::REG_MIN_US, 16'(mn));
        write_reg(scm_pkg::REG_CENTER_US, 16'(ct));
        write_reg(scm_pkg::REG_MAX_US, 16'(mx));
        write_reg(scm_pkg::REG_INVERT_DIR, 16'(inv));
        write_reg(scm_pkg::REG_CLOSED_US, 16'(cl));
        write_reg(scm_pkg::REG_HALF_US, 16'(hf));
        write_reg(scm_pkg::REG_OPEN_US, 16'(op));
    endtask

    // Offers one request word and waits until it is accepted.
    task automatic send_request(scm_pkg::t_action act, logic signed [15:0] ang,
                                logic [16:0] opn, logic [15:0] pls, bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.action = act; req_ch.angle_in = ang;
        req_ch.openness_in = opn; req_ch.pulse_in = pls;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(act, ang, opn, pls);
        sent++;
        @(negedge i_clk);
        // Without a gap, the next call raises valid again in this same time step.
        req_ch.valid = 1'b0;
    endtask

    // Random request: near-boundary values often, full range otherwise.
    task automatic send_random(bit with_gap);
        logic signed [15:0] ang;
        logic [16:0] opn;
        logic [15:0] pls;
        ang = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'($signed($urandom_range(0, 23100)) - 11550);
        case ($urandom_range(0, 3))
            0: opn = 17'($urandom);
            1: opn = 17'(FULL_OPEN - $urandom_range(0, 3));
            default: opn = 17'($urandom_range(0, FULL_OPEN));
        endcase
        pls = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 4000));
        send_request(scm_pkg::t_action'($urandom_range(0, 3)), ang, opn, pls, with_gap);
    endtask

    task automatic drain();
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic directed_set();
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, -16'sd32768, 0, 0, 0);
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, 16'sd32767, 0, 0, 0);
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, 16'sd11520, 0, 0, 0);
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, -16'sd11520, 0, 0, 0);
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, 16'sd0, 0, 0, 0);
        send_request(scm_pkg::ACT_ANGLE_TO_PULSE, 16'sd1, 0, 0, 0);
        send_request(scm_pkg::ACT_OPEN_TO_PULSE, 0, 17'd0, 0, 0);
        send_request(scm_pkg::ACT_OPEN_TO_PULSE, 0, 17'd32768, 0, 0);
        send_request(scm_pkg::ACT_OPEN_TO_PULSE, 0, 17'd65536, 0, 0);
        send_request(scm_pkg::ACT_OPEN_TO_PULSE, 0, 17'h1FFFF, 0, 0);
        send_request(scm_pkg::ACT_OPEN_TO_PULSE, 0, 17'd32769, 0, 0);
        send_request(scm_pkg::ACT_PULSE_TO_ANGLE, 0, 0, 16'd0, 0);
        send_request(scm_pkg::ACT_PULSE_TO_ANGLE, 0, 0, 16'hFFFF, 0);
        send_request(scm_pkg::ACT_PULSE_TO_ANGLE, 0, 0, 16'd1500, 0);
        send_request(scm_pkg::ACT_PULSE_TO_ANGLE, 0, 0, 16'd1001, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'd0, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'hFFFF, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'd1000, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'd1500, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'd2000, 0);
        send_request(scm_pkg::ACT_PULSE_TO_OPEN, 0, 0, 16'd1750, 0);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) res_ch.ready = 1'b0;
            else if (!res_ch.ready) res_ch.ready = (gap_len() == 0);
            else res_ch.ready = ($urandom_range(0, 5) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.pulse_out, res_ch.angle_out, res_ch.openness_out);
    end

    // Stimulus and end of run.
    initial begin
        board = new();
        board.cal = '{1000, 1500, 2000, 0, 1000, 1500, 2000};
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.action = scm_pkg::ACT_ANGLE_TO_PULSE;
        req_ch.angle_in = '0; req_ch.openness_in = '0; req_ch.pulse_in = '0;
        hold_off = 1'b0;
        sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset calibration, directed cases, then the pipeline-fill stall.
        directed_set();
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (120) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (60) send_random(0);
        join
        hold_off = 1'b0;
        drain();

        // Each phase gets its own calibration.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_cal(1000, 1500, 2000, 1, 2000, 1500, 1000);
                1: load_cal(0, 0, 65535, 0, 0, 0, 65535);
                2: load_cal(65535, 65535, 65535, 1, 65535, 65535, 65535);
                3: load_cal(2000, 1500, 1000, 0, 1000, 1000, 2000);
                4: load_cal(65535, 0, 65535, 1, 65535, 0, 0);
                5: load_cal(500, 1500, 1500, 0, 1200, 1800, 1800);
                default: load_cal($urandom_range(0, 3000), $urandom_range(0, 3000),
                                  $urandom_range(0, 3000), $urandom_range(0, 1),
                                  $urandom_range(0, 3000), $urandom_range(0, 3000),
                                  $urandom_range(0, 3000));
            endcase
            if (ph < 2) directed_set();
            repeat (ph == 7 ? 300 : 160) send_random(1);
            req_ch.valid = 1'b0;
            drain();
        end

        $display("Covered %0d requests, %0d results checked, over 9 calibrations",
                 sent, board.checked);
        $display("including inverted and degenerate spans and a full pipeline stall.");
        if (board.errors == 0 && board.owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else begin
            if (board.errors > 10) $display("%0d mismatches in total", board.errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
